[hdl/mcorb_pkg.sv]
// Package: shared types, channel tables and widths for the multi-channel ring buffer.
`timescale 1ns / 1ps
package mcorb_pkg;

	localparam int NUM_CH      = 5;
	localparam int IMU_DEPTH   = 256;
	localparam int BARO_DEPTH  = 128;
	localparam int MAG_DEPTH   = 128;
	localparam int BNO_DEPTH   = 128;
	localparam int GPS_DEPTH   = 64;
	localparam int SAMPLE_BITS = 64;

	localparam int CH_DEPTH [NUM_CH] = '{IMU_DEPTH, BARO_DEPTH, MAG_DEPTH, BNO_DEPTH, GPS_DEPTH};
	localparam int CH_BASE [NUM_CH] = '{
		0,
		IMU_DEPTH,
		IMU_DEPTH + BARO_DEPTH,
		IMU_DEPTH + BARO_DEPTH + MAG_DEPTH,
		IMU_DEPTH + BARO_DEPTH + MAG_DEPTH + BNO_DEPTH
	};

	function automatic int max_depth();
		int m;
		m = 0;
		for (int i = 0; i < NUM_CH; i++) begin
			if (CH_DEPTH[i] > m) begin
				m = CH_DEPTH[i];
			end
		end
		return m;
	endfunction

	localparam int STORE_DEPTH = IMU_DEPTH + BARO_DEPTH + MAG_DEPTH + BNO_DEPTH + GPS_DEPTH;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);
	localparam int MAX_DEPTH   = max_depth();
	localparam int PTR_W       = $clog2(MAX_DEPTH);
	localparam int CH_W        = 3;
	localparam int TS_W        = 32;
	localparam int CNT_W       = 32;
	localparam int PCT_W       = 7;
	localparam int PCT_RESET   = 80;
	localparam int PCT_SCALE   = 100;
	localparam int THR_W       = $clog2(MAX_DEPTH * ((1 << PCT_W) - 1) + 1);

	// channel codes
	localparam logic [CH_W-1:0] CH_IMU  = 3'd0;
	localparam logic [CH_W-1:0] CH_BARO = 3'd1;

	// bus widths
	localparam int S_TDATA_W = 104;
	localparam int M_TDATA_W = 184;

	// queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = 1;

	typedef struct packed {
		logic [CH_W-1:0]        ch;
		logic [SAMPLE_BITS-1:0] sample;
		logic [TS_W-1:0]        pkt_ts;
		logic                   est;
	} entry_t;

endpackage

[hdl/mcorb_ram.sv]
// Generic single-write, single-read RAM with registered, write-through read.
`timescale 1ns / 1ps
module mcorb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= (we && (waddr == raddr)) ? wdata : mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hdl/mcorb_front.sv]
// Front end: unpacks the input transfer, drops bad channel codes, tags estimator copies.
`timescale 1ns / 1ps
module mcorb_front
	import mcorb_pkg::*;
(
	input  logic                 s_valid,
	output logic                 s_ready,
	input  logic [S_TDATA_W-1:0] s_data,
	input  logic [CH_W-1:0]      s_user,
	output logic                 push,
	output entry_t               push_entry,
	input  logic                 q_ready
);

	logic                   active;
	logic                   ch_ok;
	logic                   est;
	logic [SAMPLE_BITS-1:0] sample;
	logic [TS_W-1:0]        ts;

	assign sample = s_data[SAMPLE_BITS-1:0];
	assign ts     = s_data[64 +: TS_W];
	assign active = s_data[96];

	assign ch_ok = ({1'b0, s_user} < (CH_W+1)'(NUM_CH));
	assign est   = active && ((s_user == CH_IMU) || (s_user == CH_BARO));

	// bad codes are consumed and dropped
	assign s_ready = q_ready;
	assign push    = s_valid && q_ready && ch_ok;

	always_comb begin
		push_entry.ch     = s_user;
		push_entry.sample = sample;
		push_entry.pkt_ts = est ? ts : '0;
		push_entry.est    = est;
	end

endmodule

[hdl/mcorb_queue.sv]
// Short queue of classified samples between front and back.
`timescale 1ns / 1ps
module mcorb_queue
	import mcorb_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   push_ready,
	output logic   pop_valid,
	output entry_t pop_entry,
	input  logic   pop
);

	entry_t          mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (count_q != (Q_AW+1)'(Q_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hdl/mcorb_back.sv]
// Back end: per-channel ring update, sample store write, threshold check, output register.
`timescale 1ns / 1ps
module mcorb_back
	import mcorb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [PCT_W-1:0]     cfg_wdata,
	input  logic                 q_valid,
	input  entry_t               q_entry,
	output logic                 q_pop,
	output logic                 m_valid,
	input  logic                 m_ready,
	output logic [M_TDATA_W-1:0] m_data,
	output logic [CH_W-1:0]      m_user
);

	logic [PTR_W-1:0] head_q [NUM_CH];
	logic [PTR_W-1:0] tail_q [NUM_CH];
	logic [PTR_W-1:0] fill_q [NUM_CH];
	logic [CNT_W-1:0] ovf_q  [NUM_CH];
	logic [CNT_W-1:0] seq_q  [NUM_CH];
	logic [THR_W-1:0] thr_q  [NUM_CH];

	logic             out_valid_q;
	logic [7:0]       widx_q;
	logic             over_q;
	logic [CNT_W-1:0] seq_out_q;
	logic             est_q;
	logic             cross_q;
	logic [CNT_W-1:0] ovf_out_q;
	logic [7:0]       fill_out_q;
	logic [CH_W-1:0]  ptype_q;
	logic [TS_W-1:0]  pts_q;

	logic [CH_W-1:0]        c;
	logic [PTR_W-1:0]       head;
	logic [PTR_W-1:0]       last;
	logic [PTR_W-1:0]       head_nx;
	logic [PTR_W-1:0]       tail_nx;
	logic                   over;
	logic [PTR_W-1:0]       fill_nx;
	logic [CNT_W-1:0]       ovf_nx;
	logic                   crossed;
	logic [PTR_W-1:0]       f;
	logic [STORE_AW-1:0]    waddr;
	logic [SAMPLE_BITS-1:0] rd_payload;
	logic [PTR_W+7:0]       head_ext;
	logic [PTR_W+7:0]       fill_ext;
	logic [63:0]            payload_out;

	assign q_pop = q_valid && (!out_valid_q || m_ready);
	assign c     = q_entry.ch;

	always_comb begin
		head    = head_q[c];
		last    = PTR_W'(CH_DEPTH[c] - 1);
		head_nx = (head == last) ? '0 : head + 1'b1;
		over    = (head_nx == tail_q[c]);
		tail_nx = (tail_q[c] == last) ? '0 : tail_q[c] + 1'b1;
		fill_nx = over ? fill_q[c] : fill_q[c] + 1'b1;
		ovf_nx  = ovf_q[c] + CNT_W'(over);
		waddr   = STORE_AW'(CH_BASE[c]) + STORE_AW'(head);
		// fill > floor(depth*pct/100) is the same as fill*100 > depth*pct
		crossed = 1'b0;
		for (int k = 0; k < NUM_CH; k++) begin
			f = (c == CH_W'(k)) ? fill_nx : fill_q[k];
			if ((THR_W'(f) * THR_W'(PCT_SCALE)) > thr_q[k]) begin
				crossed = 1'b1;
			end
		end
		head_ext = {8'b0, head};
		fill_ext = {8'b0, fill_nx};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_CH; k++) begin
				head_q[k] <= '0;
				tail_q[k] <= '0;
				fill_q[k] <= '0;
				ovf_q[k]  <= '0;
				seq_q[k]  <= '0;
				thr_q[k]  <= THR_W'(CH_DEPTH[k] * PCT_RESET);
			end
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				for (int k = 0; k < NUM_CH; k++) begin
					thr_q[k] <= THR_W'(CH_DEPTH[k]) * THR_W'(cfg_wdata);
				end
			end
			if (q_pop) begin
				head_q[c] <= head_nx;
				fill_q[c] <= fill_nx;
				ovf_q[c]  <= ovf_nx;
				seq_q[c]  <= seq_q[c] + 1'b1;
				if (over) begin
					tail_q[c] <= tail_nx;
				end
				out_valid_q <= 1'b1;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			widx_q     <= head_ext[7:0];
			over_q     <= over;
			seq_out_q  <= seq_q[c];
			est_q      <= q_entry.est;
			cross_q    <= crossed;
			ovf_out_q  <= ovf_nx;
			fill_out_q <= fill_ext[7:0];
			ptype_q    <= q_entry.est ? c : '0;
			pts_q      <= q_entry.pkt_ts;
		end
	end

	// read-through at the written slot gives the stored payload with the result
	mcorb_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (q_pop),
		.waddr (waddr),
		.wdata (q_entry.sample),
		.re    (q_pop),
		.raddr (waddr),
		.rdata (rd_payload)
	);

	assign payload_out = est_q ? 64'(rd_payload) : 64'b0;

	assign m_valid = out_valid_q;
	assign m_user  = ptype_q;
	assign m_data  = {5'b0, payload_out, pts_q, fill_out_q, ovf_out_q, cross_q, est_q,
		seq_out_q, over_q, widx_q};

endmodule

[hdl/multi_channel_overwrite_ring_buffer.sv]
// Top level: five-channel sensor ring buffer with overwrite of the oldest entry.
`timescale 1ns / 1ps
// Usage:
//   s_axis carries one sensor sample per transfer: tuser holds the channel
//   (0 imu, 1 baro, 2 mag, 3 bno, 4 gps), tdata the sample, timestamp and the
//   estimator-active flag. Channel codes 5..7 are consumed and dropped; they
//   change nothing and give no result.
//   m_axis returns one result per kept sample: slot written, overwrite flag,
//   sequence number, estimator flag, threshold flag, overflow count, fill
//   level and the estimator packet (type in tuser, zero unless flagged).
//   cfg_we/cfg_wdata write the fill threshold percentage; write it idle only.
//   m_axis_tvalid is registered: the input transfer is written into the queue,
//   popped into the back end, and the result register then raises it; one sample
//   per cycle is sustained while m_axis_tready stays high.
//   A 2-entry queue decouples input acceptance from the output register: when
//   m_axis stalls the output holds, the queue fills and s_axis_tready drops.
//   Reset clears all pointers and counters and sets the threshold to 80%.
//   The sample store needs no clearing; it is only read at the slot just written.
module multi_channel_overwrite_ring_buffer
	import mcorb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [PCT_W-1:0]     cfg_wdata,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// [63:0] sample, [95:64] sample_time, [96] estimator_active, rest zero
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	// [2:0] channel
	input  logic [CH_W-1:0]      s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// [7:0] write_index, [8] overwrote_oldest, [40:9] sequence_number,
	// [41] to_estimator, [42] threshold_crossed, [74:43] overflow_total,
	// [82:75] fill_level, [114:83] packet_timestamp, [178:115] packet_payload
	output logic [M_TDATA_W-1:0] m_axis_tdata,
	// [2:0] packet_type
	output logic [CH_W-1:0]      m_axis_tuser
);

	logic   push;
	entry_t push_entry;
	logic   q_ready;
	logic   q_valid;
	entry_t q_entry;
	logic   q_pop;

	// classify and accept
	mcorb_front u_front (
		.s_valid    (s_axis_tvalid),
		.s_ready    (s_axis_tready),
		.s_data     (s_axis_tdata),
		.s_user     (s_axis_tuser),
		.push       (push),
		.push_entry (push_entry),
		.q_ready    (q_ready)
	);

	// decoupling queue
	mcorb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.push_ready (q_ready),
		.pop_valid  (q_valid),
		.pop_entry  (q_entry),
		.pop        (q_pop)
	);

	// ring update and result
	mcorb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_pop     (q_pop),
		.m_valid   (m_axis_tvalid),
		.m_ready   (m_axis_tready),
		.m_data    (m_axis_tdata),
		.m_user    (m_axis_tuser)
	);

endmodule

[tb/mcorb_checker.sv]
// Checker for the ring buffer: tracks the channel rings and compares every result transfer.
`timescale 1ns / 1ps
module mcorb_checker
	import mcorb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [PCT_W-1:0]     cfg_wdata,
	input  logic                 s_axis_tvalid,
	input  logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	input  logic [CH_W-1:0]      s_axis_tuser,
	input  logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  logic [M_TDATA_W-1:0] m_axis_tdata,
	input  logic [CH_W-1:0]      m_axis_tuser,
	output int                   mismatch_count,
	output int                   writes_in_flight
);

	typedef struct {
		logic [7:0]             write_index;
		logic                   overwrote;
		logic [CNT_W-1:0]       seq_no;
		logic                   to_est;
		logic                   over_thr;
		logic [CNT_W-1:0]       ovf_total;
		logic [7:0]             fill;
		logic [CH_W-1:0]        pkt_type;
		logic [TS_W-1:0]        pkt_ts;
		logic [SAMPLE_BITS-1:0] pkt_payload;
	} ring_write_t;

	int               head_slot [NUM_CH];
	int               tail_slot [NUM_CH];
	logic [CNT_W-1:0] overflows [NUM_CH];
	logic [CNT_W-1:0] next_seq [NUM_CH];
	logic [PCT_W-1:0] fill_pct;
	ring_write_t      queued_writes [$];
	ring_write_t      oldest;

	function automatic int ring_fill(input int c);
		if (head_slot[c] >= tail_slot[c]) begin
			return head_slot[c] - tail_slot[c];
		end
		return CH_DEPTH[c] - tail_slot[c] + head_slot[c];
	endfunction

	// one kept sample: advance the ring, drop the oldest when full, number it
	function automatic ring_write_t ring_write(input logic [CH_W-1:0] ch,
			input logic [SAMPLE_BITS-1:0] smp, input logic [TS_W-1:0] ts, input logic est);
		ring_write_t r;
		int          c;
		int          depth;
		int          slot;
		int          nxt;
		int          i;
		c     = int'(ch);
		depth = CH_DEPTH[c];
		slot  = head_slot[c];
		if (slot >= depth) begin
			slot = 0;
		end
		nxt = (slot + 1) % depth;
		r.overwrote = 1'b0;
		if (nxt == tail_slot[c]) begin
			overflows[c] = overflows[c] + 1'b1;
			tail_slot[c] = (tail_slot[c] + 1) % depth;
			r.overwrote  = 1'b1;
		end
		head_slot[c] = nxt;
		r.seq_no     = next_seq[c];
		next_seq[c]  = next_seq[c] + 1'b1;
		r.to_est     = est && (ch == CH_IMU || ch == CH_BARO);
		r.over_thr   = 1'b0;
		for (i = 0; i < NUM_CH; i++) begin
			if (ring_fill(i) > (CH_DEPTH[i] * int'(fill_pct)) / PCT_SCALE) begin
				r.over_thr = 1'b1;
			end
		end
		r.write_index = slot[7:0];
		r.ovf_total   = overflows[c];
		r.fill        = 8'(ring_fill(c));
		r.pkt_type    = r.to_est ? ch : '0;
		r.pkt_ts      = r.to_est ? ts : '0;
		r.pkt_payload = r.to_est ? smp : '0;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CH; c++) begin
				head_slot[c] = 0;
				tail_slot[c] = 0;
				overflows[c] = '0;
				next_seq[c]  = '0;
			end
			fill_pct = PCT_W'(PCT_RESET);
			queued_writes.delete();
			writes_in_flight = 0;
			mismatch_count   = 0;
		end else begin
			if (cfg_we) begin
				fill_pct = cfg_wdata;
			end
			// results first: latency keeps a same-edge input from being the match
			if (m_axis_tvalid && m_axis_tready) begin
				if (queued_writes.size() == 0) begin
					$error("result transfer with no sample outstanding");
					mismatch_count++;
				end else begin
					oldest = queued_writes.pop_front();
					check_field("write_index", oldest.write_index, m_axis_tdata[7:0]);
					check_field("overwrote_oldest", oldest.overwrote, m_axis_tdata[8]);
					check_field("sequence_number", oldest.seq_no, m_axis_tdata[40:9]);
					check_field("to_estimator", oldest.to_est, m_axis_tdata[41]);
					check_field("threshold_crossed", oldest.over_thr, m_axis_tdata[42]);
					check_field("overflow_total", oldest.ovf_total, m_axis_tdata[74:43]);
					check_field("fill_level", oldest.fill, m_axis_tdata[82:75]);
					check_field("packet_timestamp", oldest.pkt_ts, m_axis_tdata[114:83]);
					check_field("packet_payload", oldest.pkt_payload, m_axis_tdata[178:115]);
					check_field("packet_type", oldest.pkt_type, m_axis_tuser);
				end
			end
			// channel codes past the last channel are swallowed without a result
			if (s_axis_tvalid && s_axis_tready && s_axis_tuser < NUM_CH) begin
				queued_writes.push_back(ring_write(s_axis_tuser, s_axis_tdata[63:0],
					s_axis_tdata[95:64], s_axis_tdata[96]));
			end
			writes_in_flight = queued_writes.size();
		end
	end

endmodule

[tb/tb_multi_channel_overwrite_ring_buffer.sv]
// Testbench top: drives samples and threshold settings into the ring buffer and gives the verdict.
`timescale 1ns / 1ps
module tb_multi_channel_overwrite_ring_buffer
	import mcorb_pkg::*;
;

	// remaining channel codes; imu and baro come from the package
	localparam logic [CH_W-1:0] CH_MAG      = 3'd2;
	localparam logic [CH_W-1:0] CH_BNO      = 3'd3;
	localparam logic [CH_W-1:0] CH_GPS      = 3'd4;
	localparam int              CH_CODE_MAX = (1 << CH_W) - 1;
	localparam int              PCT_MAX     = (1 << PCT_W) - 1;

	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 135;
	localparam int HOLD_PHASE      = 2;    // phase in which the receiver holds off
	localparam int RX_HOLD_CYCLES  = 300;
	localparam int SETTLE_CYCLES   = 6;    // covers the result latency plus margin
	localparam int CYCLE_LIMIT     = 200000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [PCT_W-1:0]     cfg_wdata;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	// [63:0] sample, [95:64] sample_time, [96] estimator_active, rest zero
	logic [S_TDATA_W-1:0] s_axis_tdata;
	// [2:0] channel
	logic [CH_W-1:0]      s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	// [7:0] write_index ... [178:115] packet_payload, see the block's port list
	logic [M_TDATA_W-1:0] m_axis_tdata;
	// [2:0] packet_type
	logic [CH_W-1:0]      m_axis_tuser;

	int mismatch_count;
	int writes_in_flight;
	int cycle_count = 0;
	bit idle_en;        // random gaps on both sides
	bit rx_hold_req;    // set by stimulus, cleared by the receiver when it starts holding

	multi_channel_overwrite_ring_buffer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	mcorb_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.s_axis_tvalid    (s_axis_tvalid),
		.s_axis_tready    (s_axis_tready),
		.s_axis_tdata     (s_axis_tdata),
		.s_axis_tuser     (s_axis_tuser),
		.m_axis_tvalid    (m_axis_tvalid),
		.m_axis_tready    (m_axis_tready),
		.m_axis_tdata     (m_axis_tdata),
		.m_axis_tuser     (m_axis_tuser),
		.mismatch_count   (mismatch_count),
		.writes_in_flight (writes_in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case a transfer never completes
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Result side. Random stall bursts while idling is on; on request one long
	// hold-off so the 2-entry queue fills and the input side backs up.
	initial begin
		int stall_left;
		stall_left    = 0;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				if (stall_left == 0 && idle_en && $urandom_range(0, 5) == 0) begin
					stall_left = $urandom_range(1, 10);
				end
				if (stall_left > 0) begin
					stall_left--;
					m_axis_tready <= 1'b0;
				end else begin
					m_axis_tready <= 1'b1;
				end
			end
		end
	end

	// Offer one sample and hold it until the transfer. Entered and left at a
	// falling edge; tvalid stays high into the next call unless a gap comes.
	task automatic offer_sample(input logic [CH_W-1:0] ch, input logic [SAMPLE_BITS-1:0] smp,
			input logic [TS_W-1:0] ts, input logic est);
		if (idle_en && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= S_TDATA_W'({est, ts, smp});
		s_axis_tuser  <= ch;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// Random sample: imu weighted up so its 256-slot ring also wraps, a few
	// out-of-range codes as noise, payload extremes now and then.
	task automatic offer_random_sample(output bit kept);
		logic [CH_W-1:0]        ch;
		logic [SAMPLE_BITS-1:0] smp;
		int                     pick;
		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			ch = CH_W'($urandom_range(NUM_CH, CH_CODE_MAX));
		end else if (pick < 45) begin
			ch = CH_IMU;
		end else begin
			ch = CH_W'($urandom_range(CH_BARO, CH_GPS));
		end
		case ($urandom_range(0, 7))
			0: smp = '0;
			1: smp = '1;
			default: smp = {$urandom, $urandom};
		endcase
		offer_sample(ch, smp, $urandom, 1'($urandom_range(0, 1)));
		kept = (ch < NUM_CH);
	endtask

	// Threshold writes only with the block drained; ignored codes give no
	// result, so some extra cycles cover anything still in the pipeline.
	task automatic set_fill_pct(input logic [PCT_W-1:0] pct);
		s_axis_tvalid <= 1'b0;
		wait (writes_in_flight == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= pct;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int pct_plan [PHASES];
		int ph;
		int sent;
		bit kept;

		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		idle_en       = 1'b1;
		rx_hold_req   = 1'b0;

		// phase 0 runs at the reset threshold; the rest sweep the extremes,
		// the just-above/below-full points and one random setting
		pct_plan = '{PCT_RESET, 0, PCT_MAX, PCT_SCALE, PCT_SCALE - 1, 1,
			$urandom_range(2, PCT_SCALE - 2), PCT_RESET};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: every channel with all-zero and all-one fields, estimator on
		offer_sample(CH_IMU, '0, '0, 1'b1);
		offer_sample(CH_IMU, '1, '1, 1'b1);
		offer_sample(CH_BARO, '0, '0, 1'b1);
		offer_sample(CH_BARO, '1, '1, 1'b1);
		offer_sample(CH_MAG, '0, '0, 1'b1);
		offer_sample(CH_MAG, '1, '1, 1'b1);
		offer_sample(CH_BNO, '0, '0, 1'b1);
		offer_sample(CH_BNO, '1, '1, 1'b1);
		offer_sample(CH_GPS, '0, '0, 1'b1);
		offer_sample(CH_GPS, '1, '1, 1'b1);
		// estimator inactive: no packet even for imu and baro
		offer_sample(CH_IMU, '1, '1, 1'b0);
		offer_sample(CH_BARO, '1, '1, 1'b0);
		// out-of-range channel codes must vanish without a result
		for (int code = NUM_CH; code <= CH_CODE_MAX; code++) begin
			offer_sample(CH_W'(code), '1, '1, 1'b1);
		end

		// random phases; rings fill up and wrap as the run goes on
		for (ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				set_fill_pct(PCT_W'(pct_plan[ph]));
			end
			if (ph == HOLD_PHASE) begin
				rx_hold_req = 1'b1;
			end
			if (ph == PHASES - 1) begin
				idle_en = 1'b0;
			end
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				offer_random_sample(kept);
				if (kept) begin
					sent++;
				end
			end
		end
		s_axis_tvalid <= 1'b0;

		// drain, then a few cycles to catch stray result transfers
		wait (writes_in_flight == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
